/* src/ar3d_pkg.sv */
// Shared types, constants and the quarter-wave sine table of the 3D axis rotator.
// Depends on nothing; every other file of the block refers to it by scoped names.
package ar3d_pkg;

  localparam int KIND_W    = 2;
  localparam int ANGLE_W   = 9;
  localparam int COEF_W    = 8;
  localparam int OUT_W     = 32;
  localparam int TAB_IDX_W = 7;

  localparam logic [ANGLE_W-1:0] ANG_90  = 9'd90;
  localparam logic [ANGLE_W-1:0] ANG_180 = 9'd180;
  localparam logic [ANGLE_W-1:0] ANG_270 = 9'd270;
  localparam logic [ANGLE_W-1:0] ANG_360 = 9'd360;

  localparam logic signed [COEF_W-1:0] COEF_UNITY = 8'sd100;
  localparam logic signed [COEF_W-1:0] COEF_ZERO  = 8'sd0;

  typedef enum logic [KIND_W-1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_e;

  // Coefficient pair of one lane: result = ka * a + kb * b
  typedef struct packed {
    logic signed [COEF_W-1:0] ka;
    logic signed [COEF_W-1:0] kb;
  } coef_t;

  // round(100 * sin(d)) for d = 0 .. 90
  localparam logic [TAB_IDX_W-1:0] SIN_TAB [0:90] = '{
    7'd0,   7'd2,   7'd3,   7'd5,   7'd7,   7'd9,   7'd10,  7'd12,  7'd14,  7'd16,
    7'd17,  7'd19,  7'd21,  7'd22,  7'd24,  7'd26,  7'd28,  7'd29,  7'd31,  7'd33,
    7'd34,  7'd36,  7'd37,  7'd39,  7'd41,  7'd42,  7'd44,  7'd45,  7'd47,  7'd48,
    7'd50,  7'd52,  7'd53,  7'd54,  7'd56,  7'd57,  7'd59,  7'd60,  7'd62,  7'd63,
    7'd64,  7'd66,  7'd67,  7'd68,  7'd69,  7'd71,  7'd72,  7'd73,  7'd74,  7'd75,
    7'd77,  7'd78,  7'd79,  7'd80,  7'd81,  7'd82,  7'd83,  7'd84,  7'd85,  7'd86,
    7'd87,  7'd87,  7'd88,  7'd89,  7'd90,  7'd91,  7'd91,  7'd92,  7'd93,  7'd93,
    7'd94,  7'd95,  7'd95,  7'd96,  7'd96,  7'd97,  7'd97,  7'd97,  7'd98,  7'd98,
    7'd98,  7'd99,  7'd99,  7'd99,  7'd99,  7'd100, 7'd100, 7'd100, 7'd100, 7'd100,
    7'd100
  };

  // Angle already reduced to 0 .. 359; fold into the first quadrant
  function automatic logic signed [COEF_W-1:0] sin100(input logic [ANGLE_W-1:0] a);
    logic [ANGLE_W-1:0]   idx;
    logic                 neg;
    logic [COEF_W-1:0]    mag;
    priority if (a <= ANG_90) begin
      idx = a;
      neg = 1'b0;
    end else if (a <= ANG_180) begin
      idx = ANG_180 - a;
      neg = 1'b0;
    end else if (a <= ANG_270) begin
      idx = a - ANG_180;
      neg = 1'b1;
    end else begin
      idx = ANG_360 - a;
      neg = 1'b1;
    end
    mag = {1'b0, SIN_TAB[idx[TAB_IDX_W-1:0]]};
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

/* src/ar3d_lane.sv */
// One multiply lane of the 3D axis rotator: two registered products and their sum.
// Depends on ar3d_pkg for the coefficient pair type.
module ar3d_lane #(
  parameter int COMP_WIDTH = 24
) (
  input  logic                                       clk_i,
  input  logic                                       en_i,
  input  logic signed [COMP_WIDTH-1:0]               a_i,
  input  logic signed [COMP_WIDTH-1:0]               b_i,
  input  ar3d_pkg::coef_t                            coef_i,
  output logic signed [COMP_WIDTH+ar3d_pkg::COEF_W:0] sum_o
);

  localparam int PW = COMP_WIDTH + ar3d_pkg::COEF_W;
  localparam int SW = PW + 1;

  logic signed [PW-1:0] pa_d, pb_d, pa_q, pb_q;

  assign pa_d = a_i * $signed(coef_i.ka);
  assign pb_d = b_i * $signed(coef_i.kb);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
  end

  assign sum_o = SW'(pa_q) + SW'(pb_q);

endmodule

/* src/ar3d_merge.sv */
// Merging stage of the 3D axis rotator: saturate the three lane sums and hold the result.
// Depends on ar3d_pkg for widths.
module ar3d_merge #(
  parameter int COMP_WIDTH = 24
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        en_i,
  input  logic                                        valid_i,
  input  logic signed [COMP_WIDTH+ar3d_pkg::COEF_W:0] sum_x_i,
  input  logic signed [COMP_WIDTH+ar3d_pkg::COEF_W:0] sum_y_i,
  input  logic signed [COMP_WIDTH+ar3d_pkg::COEF_W:0] sum_z_i,
  output logic                                        valid_o,
  output logic signed [ar3d_pkg::OUT_W-1:0]           x_o,
  output logic signed [ar3d_pkg::OUT_W-1:0]           y_o,
  output logic signed [ar3d_pkg::OUT_W-1:0]           z_o
);

  localparam int SW = COMP_WIDTH + ar3d_pkg::COEF_W + 1;
  localparam int EW = (SW > ar3d_pkg::OUT_W) ? SW : ar3d_pkg::OUT_W + 1;
  localparam logic signed [EW-1:0] SAT_MAX = EW'(2147483647);
  localparam logic signed [EW-1:0] SAT_MIN = EW'(-2147483647 - 1);

  function automatic logic signed [ar3d_pkg::OUT_W-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [EW-1:0] e;
    e = EW'(v);
    if (e > SAT_MAX) begin
      e = SAT_MAX;
    end else if (e < SAT_MIN) begin
      e = SAT_MIN;
    end
    return $signed(e[ar3d_pkg::OUT_W-1:0]);
  endfunction

  logic valid_q;
  logic signed [ar3d_pkg::OUT_W-1:0] x_q, y_q, z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      x_q <= sat(sum_x_i);
      y_q <= sat(sum_y_i);
      z_q <= sat(sum_z_i);
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

/* src/axis_rotation_3d.sv */
// Top level of the 3D axis rotator: angle folding, operand steering, three lanes, merge.
// Depends on ar3d_pkg, ar3d_lane and ar3d_merge.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------------
//   in      | input     | in_valid_i / in_stall_o | kind_i angle_deg_i x_in_i y_in_i z_in_i
//   out     | output    | out_valid_o / out_stall_i | x_out_o y_out_o z_out_o
//
// One item enters per cycle while in_stall_o is low and passes three registers in turn: decode
// and steering register, product register in each lane, saturated output register.
// Every stage holds its item only while the stage after it is full and held,
// so a waiting result never blocks the stages behind it from filling.
// Reset (rst_ni low, asynchronous) empties all three stages; payload keeps no reset.
// A stall at the output backs up stage by stage; nothing is dropped or repeated.
module axis_rotation_3d #(
  parameter int COMP_WIDTH = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ar3d_pkg::KIND_W-1:0]         kind_i,
  input  logic [ar3d_pkg::ANGLE_W-1:0]        angle_deg_i,
  input  logic signed [COMP_WIDTH-1:0]        x_in_i,
  input  logic signed [COMP_WIDTH-1:0]        y_in_i,
  input  logic signed [COMP_WIDTH-1:0]        z_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ar3d_pkg::OUT_W-1:0]   x_out_o,
  output logic signed [ar3d_pkg::OUT_W-1:0]   y_out_o,
  output logic signed [ar3d_pkg::OUT_W-1:0]   z_out_o
);

  localparam int NLANES = 3;
  localparam int SW     = COMP_WIDTH + ar3d_pkg::COEF_W + 1;

  // Stage enables: a stage loads when it is empty or its successor moves on
  logic en1, en2, en3;
  logic v1_q, v2_q;

  assign en3        = !out_valid_o || !out_stall_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;

  // Angle folding: reduce to 0 .. 359, then cosine as sine shifted a quarter turn
  logic [ar3d_pkg::ANGLE_W-1:0]        ang_red, cos_arg;
  logic signed [ar3d_pkg::COEF_W-1:0]  s, c, ns;

  logic signed [COMP_WIDTH-1:0] opa_d [NLANES];
  logic signed [COMP_WIDTH-1:0] opb_d [NLANES];
  ar3d_pkg::coef_t              coef_d [NLANES];
  logic signed [COMP_WIDTH-1:0] opa_q [NLANES];
  logic signed [COMP_WIDTH-1:0] opb_q [NLANES];
  ar3d_pkg::coef_t              coef_q [NLANES];

  always_comb begin
    ang_red = (angle_deg_i >= ar3d_pkg::ANG_360) ? angle_deg_i - ar3d_pkg::ANG_360
                                                  : angle_deg_i;
    cos_arg = ang_red + ar3d_pkg::ANG_90;
    if (cos_arg >= ar3d_pkg::ANG_360) begin
      cos_arg = cos_arg - ar3d_pkg::ANG_360;
    end
    s  = ar3d_pkg::sin100(ang_red);
    c  = ar3d_pkg::sin100(cos_arg);
    ns = -s;
  end

  // Steer operands: each lane keeps its own component as a and picks the
  // partner component as b; the kept axis scales by 100 with b unused.
  always_comb begin
    opa_d[0] = x_in_i;
    opa_d[1] = y_in_i;
    opa_d[2] = z_in_i;
    opb_d[0] = x_in_i;
    opb_d[1] = y_in_i;
    opb_d[2] = z_in_i;
    for (int i = 0; i < NLANES; i++) begin
      coef_d[i] = '{ka: ar3d_pkg::COEF_UNITY, kb: ar3d_pkg::COEF_ZERO};
    end
    unique case (ar3d_pkg::axis_e'(kind_i))
      ar3d_pkg::AXIS_X: begin
        opb_d[1]  = z_in_i;
        coef_d[1] = '{ka: c, kb: ns};
        opb_d[2]  = y_in_i;
        coef_d[2] = '{ka: c, kb: s};
      end
      ar3d_pkg::AXIS_Y: begin
        opb_d[0]  = z_in_i;
        coef_d[0] = '{ka: c, kb: s};
        opb_d[2]  = x_in_i;
        coef_d[2] = '{ka: c, kb: ns};
      end
      ar3d_pkg::AXIS_Z: begin
        opb_d[0]  = y_in_i;
        coef_d[0] = '{ka: c, kb: ns};
        opb_d[1]  = x_in_i;
        coef_d[1] = '{ka: c, kb: s};
      end
      ar3d_pkg::AXIS_NONE: begin
        // no rotation: every lane scales its own component
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      opa_q  <= opa_d;
      opb_q  <= opb_d;
      coef_q <= coef_d;
    end
  end

  // Lanes: one per output component
  logic signed [SW-1:0] sum [NLANES];

  for (genvar g = 0; g < NLANES; g++) begin : g_lane
    ar3d_lane #(
      .COMP_WIDTH(COMP_WIDTH)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (en2),
      .a_i   (opa_q[g]),
      .b_i   (opb_q[g]),
      .coef_i(coef_q[g]),
      .sum_o (sum[g])
    );
  end

  // Merge: saturate and hold the result until it is taken
  ar3d_merge #(
    .COMP_WIDTH(COMP_WIDTH)
  ) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en3),
    .valid_i(v2_q),
    .sum_x_i(sum[0]),
    .sum_y_i(sum[1]),
    .sum_z_i(sum[2]),
    .valid_o(out_valid_o),
    .x_o    (x_out_o),
    .y_o    (y_out_o),
    .z_o    (z_out_o)
  );

endmodule

/* src/ar3d_checker.sv */
// Port-level checks of the 3D axis rotator, attached to the top level by bind.
// Depends on ar3d_pkg for widths.
module ar3d_checker #(
  parameter int COMP_WIDTH = 24
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [ar3d_pkg::ANGLE_W-1:0]      angle_deg_i,
  input logic signed [COMP_WIDTH-1:0]      x_in_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [ar3d_pkg::OUT_W-1:0] x_out_o,
  input logic signed [ar3d_pkg::OUT_W-1:0] y_out_o,
  input logic signed [ar3d_pkg::OUT_W-1:0] z_out_o
);

  // A held result keeps its values
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(x_out_o) && $stable(y_out_o)
      && $stable(z_out_o))
    else $error("held result changed");

  // With the output stage empty the input must be taken
  a_accept_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output stage empty");

  // An accepted item reaches the output when the output is not held in between
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("item did not arrive after three cycles");

  // Zero angle scales the x component by 100
  a_zero_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && angle_deg_i == '0 && COMP_WIDTH <= 24)
      ##1 !out_stall_i ##1 !out_stall_i
      |=> $signed(x_out_o) == 100 * $signed($past(x_in_i, 3)))
    else $error("zero angle result wrong");

endmodule

bind axis_rotation_3d ar3d_checker #(
  .COMP_WIDTH(COMP_WIDTH)
) u_ar3d_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .angle_deg_i(angle_deg_i),
  .x_in_i     (x_in_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .x_out_o    (x_out_o),
  .y_out_o    (y_out_o),
  .z_out_o    (z_out_o)
);
